/* rtl/core/wcs_pkg.sv */
// ----------------------------------------------------------------------------
// wcs_pkg
// shared constants, types and the walsh row table for the chip spreader
// ----------------------------------------------------------------------------
package wcs_pkg;

    localparam int MAX_CHIPS  = 64;
    localparam int WALSH_SIZE = 16;

    localparam int SYM_W    = 8;
    localparam int CFG_W    = 7;
    localparam int SAMPLE_W = 5;
    localparam int IDX_W    = $clog2(MAX_CHIPS);
    localparam int COL_W    = $clog2(WALSH_SIZE);
    // remainder stays below cc + WALSH_SIZE
    localparam int REM_W    = $clog2(MAX_CHIPS + WALSH_SIZE);

    localparam logic [CFG_W-1:0] CHIPS_RESET = CFG_W'(16);

    // odd walsh rows, one per symbol bit
    localparam logic [COL_W-1:0] ROW_SEL [SYM_W] = '{
        COL_W'(1), COL_W'(3), COL_W'(5), COL_W'(7),
        COL_W'(9), COL_W'(11), COL_W'(13), COL_W'(15)
    };

    // control of the column unit
    typedef struct packed {
        logic load;   // clear column and remainder for a new symbol
        logic sub;    // one compare-subtract step, column moves on
        logic adv;    // next chip, remainder grows by the walsh size
    } t_col_ctrl;

endpackage

/* rtl/core/wcs_col_unit.sv */
// ----------------------------------------------------------------------------
// wcs_col_unit
// shared compare-subtract unit that tracks floor(16*j/cc) chip by chip
// ----------------------------------------------------------------------------
module wcs_col_unit (
    input  logic                        i_clk,
    input  wcs_pkg::t_col_ctrl          i_ctrl,
    input  logic [wcs_pkg::CFG_W-1:0]   i_cc,
    output logic [wcs_pkg::COL_W-1:0]   o_col,
    output logic                        o_fits
);

    logic [wcs_pkg::REM_W-1:0] r_rem;
    logic [wcs_pkg::COL_W-1:0] r_col;
    logic [wcs_pkg::REM_W-1:0] w_cc;

    assign w_cc   = wcs_pkg::REM_W'(i_cc);
    // remainder below cc means the column is settled for this chip
    assign o_fits = r_rem < w_cc;
    assign o_col  = r_col;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_rem <= '0;
            r_col <= '0;
        end else if (i_ctrl.sub) begin
            r_rem <= r_rem - w_cc;
            r_col <= r_col + wcs_pkg::COL_W'(1);
        end else if (i_ctrl.adv) begin
            r_rem <= r_rem + wcs_pkg::REM_W'(wcs_pkg::WALSH_SIZE);
        end
    end

endmodule

/* rtl/core/wcs_chip_sum.sv */
// ----------------------------------------------------------------------------
// wcs_chip_sum
// sum of the selected walsh signs for one column
// ----------------------------------------------------------------------------
module wcs_chip_sum (
    input  logic [wcs_pkg::SYM_W-1:0]           i_bits,
    input  logic [wcs_pkg::COL_W-1:0]           i_col,
    output logic signed [wcs_pkg::SAMPLE_W-1:0] o_sample
);

    always_comb begin
        logic signed [wcs_pkg::SAMPLE_W-1:0] acc;
        acc = '0;
        for (int l = 0; l < wcs_pkg::SYM_W; l++) begin
            if (i_bits[l]) begin
                // odd parity of row and column gives a minus sign
                if (^(wcs_pkg::ROW_SEL[l] & i_col))
                    acc = acc - wcs_pkg::SAMPLE_W'(1);
                else
                    acc = acc + wcs_pkg::SAMPLE_W'(1);
            end
        end
        o_sample = acc;
    end

endmodule

/* rtl/core/walsh_code_spreader_top.sv */
// ----------------------------------------------------------------------------
// walsh_code_spreader_top
// 16-point walsh-hadamard spreader, one 8-bit symbol in, cc chip samples out
// ----------------------------------------------------------------------------
// Each transfer on the input channel brings one symbol; the block then gives
// cc chip samples, cc being chips_per_symbol (0 reads as 1, above 64 reads
// as 64), each with its chip index and a flag on the last chip. The chip
// column floor(16*j/cc) is followed by a single compare-subtract unit: each
// cycle it steps the column on by one or, once the column is settled and
// the output register is free, hands a chip to that register; a settled
// chip waits while the output stalls. o_ready is high only while no symbol
// is in progress. A new symbol may be taken while the last chip of the
// previous one still waits in the output register.
// chips_per_symbol is sampled at the input transfer, so it should be
// written only between symbols.
// ----------------------------------------------------------------------------
module walsh_code_spreader_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration write
    input  logic                                i_cfg_wr_en,
    input  logic [wcs_pkg::CFG_W-1:0]           i_cfg_wr_data,
    // symbol input
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [wcs_pkg::SYM_W-1:0]           i_symbol_bits,
    // chip output
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [wcs_pkg::SAMPLE_W-1:0] o_sample_value,
    output logic [wcs_pkg::IDX_W-1:0]           o_chip_index,
    output logic                                o_last_chip
);

    typedef enum logic {
        S_IDLE,
        S_RUN
    } t_state;

    t_state                              r_state;
    logic [wcs_pkg::CFG_W-1:0]           r_chips_cfg;
    logic [wcs_pkg::CFG_W-1:0]           r_cc_eff;
    logic [wcs_pkg::SYM_W-1:0]           r_held_bits;
    logic [wcs_pkg::IDX_W-1:0]           r_j;
    logic                                r_o_valid;
    logic signed [wcs_pkg::SAMPLE_W-1:0] r_o_sample;
    logic [wcs_pkg::IDX_W-1:0]           r_o_index;
    logic                                r_o_last;

    logic [wcs_pkg::CFG_W-1:0]           n_cc_eff;
    wcs_pkg::t_col_ctrl                  w_ctrl;
    logic [wcs_pkg::COL_W-1:0]           w_col;
    logic                                w_fits;
    logic signed [wcs_pkg::SAMPLE_W-1:0] w_sample;
    logic                                w_accept;
    logic                                w_emit;
    logic                                w_last;

    // clamp the chip count into 1..MAX_CHIPS
    always_comb begin
        if (r_chips_cfg == '0)
            n_cc_eff = wcs_pkg::CFG_W'(1);
        else if (r_chips_cfg > wcs_pkg::CFG_W'(wcs_pkg::MAX_CHIPS))
            n_cc_eff = wcs_pkg::CFG_W'(wcs_pkg::MAX_CHIPS);
        else
            n_cc_eff = r_chips_cfg;
    end

    assign o_ready  = (r_state == S_IDLE);
    assign w_accept = i_valid && o_ready;
    // a chip leaves when its column is settled and the output slot is free
    assign w_emit   = (r_state == S_RUN) && w_fits && (!r_o_valid || i_ready);
    assign w_last   = (r_j == wcs_pkg::IDX_W'(r_cc_eff - wcs_pkg::CFG_W'(1)));

    assign w_ctrl.load = w_accept;
    assign w_ctrl.sub  = (r_state == S_RUN) && !w_fits;
    assign w_ctrl.adv  = w_emit && !w_last;

    wcs_col_unit u_col (
        .i_clk  (i_clk),
        .i_ctrl (w_ctrl),
        .i_cc   (r_cc_eff),
        .o_col  (w_col),
        .o_fits (w_fits)
    );

    wcs_chip_sum u_sum (
        .i_bits   (r_held_bits),
        .i_col    (w_col),
        .o_sample (w_sample)
    );

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chips_cfg <= wcs_pkg::CHIPS_RESET;
        end else if (i_cfg_wr_en) begin
            r_chips_cfg <= i_cfg_wr_data;
        end
    end

    // sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_o_valid   <= 1'b0;
            r_j         <= '0;
            r_cc_eff    <= wcs_pkg::CFG_W'(1);
            r_held_bits <= '0;
        end else begin
            // output slot fills on a new chip and empties on its transfer
            if (w_emit)
                r_o_valid <= 1'b1;
            else if (o_valid && i_ready)
                r_o_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_held_bits <= i_symbol_bits;
                        r_cc_eff    <= n_cc_eff;
                        r_j         <= '0;
                        r_state     <= S_RUN;
                    end
                end
                S_RUN: begin
                    if (w_emit) begin
                        r_o_sample <= w_sample;
                        r_o_index  <= r_j;
                        r_o_last   <= w_last;
                        if (w_last)
                            r_state <= S_IDLE;
                        else
                            r_j <= r_j + wcs_pkg::IDX_W'(1);
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid        = r_o_valid;
    assign o_sample_value = r_o_sample;
    assign o_chip_index   = r_o_index;
    assign o_last_chip    = r_o_last;

`ifndef SYNTHESIS
    // a new symbol starts its run at chip zero
    a_start_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_RUN) && (r_j == '0))
        else $error("run did not start at chip zero");

    // the last chip closes the run
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit && w_last) |=> (r_state == S_IDLE))
        else $error("run did not end after last chip");

    // chip position never reaches the chip count
    a_j_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> (wcs_pkg::CFG_W'(r_j) < r_cc_eff))
        else $error("chip position out of range");

    // latched chip count stays clamped
    a_cc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cc_eff != '0) && (r_cc_eff <= wcs_pkg::CFG_W'(wcs_pkg::MAX_CHIPS)))
        else $error("chip count not clamped");
`endif

endmodule

/* test/tb_walsh_code_spreader_top.sv */
// ----------------------------------------------------------------------------
// tb_walsh_code_spreader_top
// self-checking bench for the 16-point walsh-hadamard chip spreader
// ----------------------------------------------------------------------------
// Symbols go in through a valid/ready sender task. A bit-exact predictor
// expands each accepted symbol into its chip samples and queues them. A
// checker pops one expected chip per output transfer and compares every
// field. The run covers the reset chip count, the chip-count extremes (zero,
// one, 64 and values above 64), random symbols over many chip counts with
// random idling on both sides, a long output hold-off that backs the block
// up, and a final stretch at full rate.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_walsh_code_spreader_top;

    localparam int CYCLE_LIMIT = 5_000_000;
    localparam int TAIL_CYCLES = 100;    // longer than one symbol at 64 chips

    // one expected chip sample
    typedef struct packed {
        logic signed [wcs_pkg::SAMPLE_W-1:0] sample;
        logic [wcs_pkg::IDX_W-1:0]           idx;
        logic                                last;
    } t_chip;

    logic                                i_clk;
    logic                                i_rst_n;
    logic                                i_cfg_wr_en;
    logic [wcs_pkg::CFG_W-1:0]           i_cfg_wr_data;
    logic                                i_valid;
    logic                                o_ready;
    logic [wcs_pkg::SYM_W-1:0]           i_symbol_bits;
    logic                                o_valid;
    logic                                i_ready;
    logic signed [wcs_pkg::SAMPLE_W-1:0] o_sample_value;
    logic [wcs_pkg::IDX_W-1:0]           o_chip_index;
    logic                                o_last_chip;

    walsh_code_spreader_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_symbol_bits  (i_symbol_bits),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_sample_value (o_sample_value),
        .o_chip_index   (o_chip_index),
        .o_last_chip    (o_last_chip)
    );

    // bench-side copy of the chip count register
    logic [wcs_pkg::CFG_W-1:0] chips_cfg;

    // chips still owed by the block, oldest first
    t_chip chip_q[$];
    t_chip head;

    int errors       = 0;
    int symbols_sent = 0;
    int chips_seen   = 0;
    int cfg_writes   = 0;
    int cycle_count  = 0;

    // idling controls for the sender and the sink process
    bit sender_gaps = 0;
    bit sink_stalls = 0;
    int sink_hold   = 0;

    // ------------------------------------------------------------------------
    // clock, 4 ns period
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // watchdog: ends the run if the block hangs
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d chips outstanding",
                     cycle_count, chip_q.size());
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // predictor: chip j uses walsh column floor(16*j/cc); the sample is the
    // signed sum of the odd-row signs picked out by the symbol bits
    // ------------------------------------------------------------------------
    function automatic void spread_symbol(input logic [wcs_pkg::SYM_W-1:0] sym);
        int unsigned cc;
        logic [wcs_pkg::COL_W-1:0] col;
        logic [wcs_pkg::COL_W-1:0] row;
        int sum;
        t_chip c;
        cc = chips_cfg;
        if (cc == 0) cc = 1;                                 // zero reads as one
        if (cc > wcs_pkg::MAX_CHIPS) cc = wcs_pkg::MAX_CHIPS; // over-range saturates
        for (int unsigned j = 0; j < cc; j++) begin
            col = wcs_pkg::COL_W'((wcs_pkg::WALSH_SIZE * j) / cc);
            sum = 0;
            for (int l = 0; l < wcs_pkg::SYM_W; l++) begin
                row = wcs_pkg::COL_W'(2 * l + 1);
                if (sym[l]) sum += (^(row & col)) ? -1 : 1;
            end
            c.sample = wcs_pkg::SAMPLE_W'(sum);
            c.idx    = wcs_pkg::IDX_W'(j);
            c.last   = (j == cc - 1);
            chip_q.push_back(c);
        end
    endfunction

    // ------------------------------------------------------------------------
    // checker: every output transfer against the oldest expected chip
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            chips_seen++;
            if (chip_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected chip, sample %0d index %0d last %0b",
                         $time, o_sample_value, o_chip_index, o_last_chip);
            end else begin
                head = chip_q.pop_front();
                if (o_sample_value !== head.sample) begin
                    errors++;
                    $display("%0t: sample_value expected %0d got %0d", $time,
                             $signed(head.sample), o_sample_value);
                end
                if (o_chip_index !== head.idx) begin
                    errors++;
                    $display("%0t: chip_index expected %0d got %0d", $time,
                             head.idx, o_chip_index);
                end
                if (o_last_chip !== head.last) begin
                    errors++;
                    $display("%0t: last_chip expected %0b got %0b", $time,
                             head.last, o_last_chip);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // chip sink: drives i_ready; random stall bursts, long hold-off on request
    // ------------------------------------------------------------------------
    initial begin : chip_sink
        int n;
        forever begin
            if (sink_hold != 0) begin
                // long hold-off, counted here so the sender keeps offering
                i_ready <= 1'b0;
                n = sink_hold;
                sink_hold = 0;
                repeat (n) @(posedge i_clk);
            end else if (sink_stalls && $urandom_range(0, 2) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge i_clk);
            end else begin
                i_ready <= 1'b1;
                repeat ($urandom_range(1, 30)) @(posedge i_clk);
            end
        end
    end

    // ------------------------------------------------------------------------
    // shared sender helpers
    // ------------------------------------------------------------------------

    // offer one symbol, predict its chips on transfer, then idle for gap
    // cycles; with no gap valid stays high for the next symbol
    task automatic send_symbol(input logic [wcs_pkg::SYM_W-1:0] sym, input int gap);
        i_valid       <= 1'b1;
        i_symbol_bits <= sym;
        do @(posedge i_clk); while (!o_ready);
        spread_symbol(sym);
        symbols_sent++;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    function automatic int pick_gap();
        if (sender_gaps && $urandom_range(0, 2) == 0)
            return $urandom_range(1, 9);
        return 0;
    endfunction

    // drop valid and wait for every owed chip to come out
    task automatic drain_chips();
        i_valid <= 1'b0;
        while (chip_q.size() != 0) @(posedge i_clk);
    endtask

    // chip count write, only with the block idle
    task automatic write_chip_count(input logic [wcs_pkg::CFG_W-1:0] value);
        drain_chips();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        chips_cfg = value;
        cfg_writes++;
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // reset chip count of 16: all-zero, all-one and every single bit
    task automatic test_default_count();
        send_symbol(8'h00, 0);
        send_symbol(8'hFF, 0);
        for (int l = 0; l < wcs_pkg::SYM_W; l++)
            send_symbol(wcs_pkg::SYM_W'(1) << l, 0);
        drain_chips();
    endtask

    // one chip, 64 chips, zero read as one, and counts above 64 saturating
    task automatic test_count_extremes();
        write_chip_count(7'd1);
        send_symbol(8'hFF, 0);
        send_symbol(8'hA5, 0);
        write_chip_count(7'd64);
        send_symbol(8'hFF, 0);
        send_symbol(8'h5A, 0);
        write_chip_count(7'd0);
        send_symbol(8'hFF, 0);
        send_symbol(8'h3C, 0);
        write_chip_count(7'd65);
        send_symbol(8'hC3, 0);
        write_chip_count(7'd127);
        send_symbol(8'hFF, 0);
        send_symbol(8'h00, 0);
        drain_chips();
    endtask

    // random symbols across many chip counts, idling mixed per phase
    task automatic test_random_symbols();
        int counts[15] = '{16, 3, 7, 1, 5, 64, 33, 12, 0, 100, 127, 2, 9, 24, -1};
        for (int p = 0; p < 15; p++) begin
            // last entry picks a random count
            write_chip_count(counts[p] < 0 ? wcs_pkg::CFG_W'($urandom_range(0, 127))
                                           : wcs_pkg::CFG_W'(counts[p]));
            sender_gaps = (p % 3 != 2);
            sink_stalls = (p % 3 != 1);
            repeat (25)
                send_symbol(wcs_pkg::SYM_W'($urandom_range(0, 255)), pick_gap());
        end
        drain_chips();
    endtask

    // receiver holds off long while symbols keep coming, block stalls input
    task automatic test_output_backpressure();
        write_chip_count(7'd5);
        sender_gaps = 0;
        sink_stalls = 0;
        sink_hold   = 300;
        repeat (8) send_symbol(wcs_pkg::SYM_W'($urandom_range(0, 255)), 0);
        drain_chips();
    endtask

    // closing stretch with no idling on either side
    task automatic test_full_rate();
        write_chip_count(7'd16);
        sender_gaps = 0;
        sink_stalls = 0;
        repeat (20) send_symbol(wcs_pkg::SYM_W'($urandom_range(0, 255)), 0);
        drain_chips();
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n       <= 1'b0;
        i_cfg_wr_en   <= 1'b0;
        i_cfg_wr_data <= '0;
        i_valid       <= 1'b0;
        i_symbol_bits <= '0;
        chips_cfg = wcs_pkg::CHIPS_RESET;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_default_count();
        test_count_extremes();
        test_random_symbols();
        test_output_backpressure();
        test_full_rate();

        // let any stray chip show up before the verdict
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("covered %0d symbols, %0d chip transfers checked", symbols_sent,
                 chips_seen);
        $display("over %0d chip-count writes incl. zero, one, 64 and above 64",
                 cfg_writes);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("%0d mismatches", errors);
            $display("FAIL");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/core/wcs_pkg.sv
rtl/core/wcs_col_unit.sv
rtl/core/wcs_chip_sum.sv
rtl/core/walsh_code_spreader_top.sv
test/tb_walsh_code_spreader_top.sv
